// ===== rtl/gregorian_date_offset_assert.svh =====
// assertion macros shared by the date offset checker
`ifndef GREGORIAN_DATE_OFFSET_ASSERT_SVH
`define GREGORIAN_DATE_OFFSET_ASSERT_SVH

// same-cycle implication, sampled on clk and off while rst_n is low
`define GDO_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, sampled on clk and off while rst_n is low
`define GDO_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/gdo_pkg.sv =====
// shared widths, constants, types and month tables for the date offset block
package gdo_pkg;

    // calendar span
    localparam int FIRST_YEAR = 1800;
    localparam int LAST_YEAR  = 9999;

    // field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OFF_W    = 23;
    localparam int STATUS_W = 2;
    localparam int WDAY_W   = 3;
    localparam int DCNT_W   = 22;

    // internal widths
    localparam int TOTAL_W  = 24;
    localparam int DIFF_W   = 23;
    localparam int DOY_W    = 9;
    localparam int QUART_W  = YEAR_W - 2;
    localparam int CENT_W   = 8;
    localparam int DSUM_W   = 6;

    // register stages from input to output
    localparam int PIPE_DEPTH = 12;

    // leap years before the first year, and days up to the year after the last one
    localparam int LEAPS_FIRST = (FIRST_YEAR - 1) / 4 - (FIRST_YEAR - 1) / 100
                               + (FIRST_YEAR - 1) / 400;
    localparam int DAYS_TOTAL  = 365 * (LAST_YEAR + 1 - FIRST_YEAR) + LAST_YEAR / 4
                               - LAST_YEAR / 100 + LAST_YEAR / 400 - LEAPS_FIRST;

    // x/25 as (x*2622)>>16, exact for x below 4681
    localparam logic [QUART_W-1:0] RECIP_25    = 12'd2622;
    localparam int                 RECIP_25_SH = 16;

    // year estimate as (t*11484)>>22, within one year of the true year
    localparam logic [YEAR_W-1:0]  RECIP_YEAR    = 14'd11484;
    localparam int                 RECIP_YEAR_SH = 22;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    // leap flags of the year before, the year itself and the year after
    typedef struct packed {
        logic prev;
        logic cur;
        logic next;
    } leap_t;

    // month length in days
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the year before the first of month m
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] base;
        logic             add;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        add = leap && (m >= 4'd3) && (m <= 4'd12);
        return base + DOY_W'(add);
    endfunction

endpackage

// ===== rtl/gregorian_date_offset.sv =====
// Gregorian date plus signed day offset: shifted date, day count since 1 Jan 1800, weekday
// Pipeline: 12 register stages from an accepted transaction to the output register.
// Throughput: one transaction per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all stage valid bits; no state survives between items.
module gregorian_date_offset
    import gdo_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [DAY_W-1:0]           day_in,
    input  logic [MONTH_W-1:0]         month_in,
    input  logic [YEAR_W-1:0]          year_in,
    input  logic signed [OFF_W-1:0]    day_offset,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [DAY_W-1:0]           day_out,
    output logic [MONTH_W-1:0]         month_out,
    output logic [YEAR_W-1:0]          year_out,
    output logic [WDAY_W-1:0]          weekday,
    output logic [DCNT_W-1:0]          day_count
);

    logic                   en;
    logic [PIPE_DEPTH-1:0]  vld_reg;

    // stage 1
    logic                   fmt_ok_next;
    logic [DAY_W-1:0]       s1_day_reg;
    logic [MONTH_W-1:0]     s1_month_reg;
    logic signed [OFF_W-1:0] s1_off_reg;
    logic                   s1_fmt_ok_reg;
    // stage 2
    logic [DAY_W-1:0]       s2_day_reg;
    logic [MONTH_W-1:0]     s2_month_reg;
    logic signed [OFF_W-1:0] s2_off_reg;
    logic                   s2_fmt_ok_reg;
    logic [DCNT_W-1:0]      fwd_days;
    leap_t                  fwd_leap;
    // stage 3
    logic                   bad_next;
    logic [DOY_W-1:0]       doy_next;
    logic                   s3_bad_reg;
    logic [DCNT_W-1:0]      s3_days_reg;
    logic [DOY_W-1:0]       s3_doy_reg;
    logic signed [OFF_W-1:0] s3_off_reg;
    // stage 4
    logic signed [TOTAL_W-1:0] total_next;
    logic                   s4_bad_reg;
    logic signed [TOTAL_W-1:0] s4_total_reg;
    // stage 5
    logic [STATUS_W-1:0]    status_next;
    logic [STATUS_W-1:0]    s5_status_reg;
    logic [DCNT_W-1:0]      s5_t_reg;
    // stage 6
    logic [DCNT_W+YEAR_W-1:0] est_prod;
    logic [YEAR_W-1:0]      ry0_next;
    logic [DSUM_W-1:0]      dsum_next;
    logic [STATUS_W-1:0]    s6_status_reg;
    logic [DCNT_W-1:0]      s6_t_reg;
    logic [YEAR_W-1:0]      s6_ry0_reg;
    logic [DSUM_W-1:0]      s6_dsum_reg;
    // stage 7
    logic [3:0]             fold;
    logic [WDAY_W-1:0]      m7_next;
    logic [STATUS_W-1:0]    s7_status_reg;
    logic [DCNT_W-1:0]      s7_t_reg;
    logic [YEAR_W-1:0]      s7_ry0_reg;
    logic [WDAY_W-1:0]      s7_m7_reg;
    // stage 8
    logic [WDAY_W-1:0]      wday_next;
    logic [STATUS_W-1:0]    s8_status_reg;
    logic [DCNT_W-1:0]      s8_t_reg;
    logic [YEAR_W-1:0]      s8_ry0_reg;
    logic [WDAY_W-1:0]      s8_wday_reg;
    logic [DCNT_W-1:0]      inv_days;
    leap_t                  inv_leap;
    // stage 9
    logic [DIFF_W-1:0]      diff_next;
    logic [STATUS_W-1:0]    s9_status_reg;
    logic [DCNT_W-1:0]      s9_t_reg;
    logic [YEAR_W-1:0]      s9_ry0_reg;
    logic [WDAY_W-1:0]      s9_wday_reg;
    logic [DIFF_W-1:0]      s9_diff_reg;
    leap_t                  s9_leap_reg;
    // stage 10
    logic [9:0]             len_cur;
    logic [YEAR_W-1:0]      ry_next;
    logic [DOY_W-1:0]       rest_next;
    logic                   lp_next;
    logic [STATUS_W-1:0]    s10_status_reg;
    logic [DCNT_W-1:0]      s10_t_reg;
    logic [YEAR_W-1:0]      s10_ry_reg;
    logic [WDAY_W-1:0]      s10_wday_reg;
    logic [DOY_W-1:0]       s10_rest_reg;
    logic                   s10_leap_reg;
    // stage 11
    logic [STATUS_W-1:0]    s11_status_reg;
    logic [DCNT_W-1:0]      s11_t_reg;
    logic [YEAR_W-1:0]      s11_ry_reg;
    logic [WDAY_W-1:0]      s11_wday_reg;
    logic [MONTH_W-1:0]     split_month;
    logic [DAY_W-1:0]       split_day;
    // stage 12
    logic                   ok;
    logic [STATUS_W-1:0]    status_reg;
    logic [DAY_W-1:0]       day_reg;
    logic [MONTH_W-1:0]     month_reg;
    logic [YEAR_W-1:0]      year_reg;
    logic [WDAY_W-1:0]      wday_reg;
    logic [DCNT_W-1:0]      count_reg;

    // whole pipeline advances unless a result waits at the output
    assign en       = !(vld_reg[PIPE_DEPTH-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // stage 1: field range checks
    assign fmt_ok_next = (year_in >= YEAR_W'(FIRST_YEAR)) && (year_in <= YEAR_W'(LAST_YEAR))
                      && (month_in >= 4'd1) && (month_in <= 4'd12) && (day_in != 5'd0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_day_reg    <= day_in;
            s1_month_reg  <= month_in;
            s1_off_reg    <= day_offset;
            s1_fmt_ok_reg <= fmt_ok_next;
        end
    end

    // days to the start of the input year, ready at stage 2
    gdo_year_days u_fwd_year (
        .clk  (clk),
        .en   (en),
        .year (year_in),
        .days (fwd_days),
        .leap (fwd_leap)
    );

    // stage 2: carry fields alongside the year unit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_day_reg    <= s1_day_reg;
            s2_month_reg  <= s1_month_reg;
            s2_off_reg    <= s1_off_reg;
            s2_fmt_ok_reg <= s1_fmt_ok_reg;
        end
    end

    // stage 3: month length check and day of year
    assign bad_next = !(s2_fmt_ok_reg && (s2_day_reg <= month_len(s2_month_reg, fwd_leap.cur)));
    assign doy_next = month_start(s2_month_reg, fwd_leap.cur) + DOY_W'(s2_day_reg) - 9'd1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_bad_reg  <= bad_next;
            s3_days_reg <= fwd_days;
            s3_doy_reg  <= doy_next;
            s3_off_reg  <= s2_off_reg;
        end
    end

    // stage 4: signed day total
    assign total_next = $signed({2'b00, s3_days_reg}) + $signed({15'd0, s3_doy_reg})
                      + TOTAL_W'(s3_off_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_bad_reg   <= s3_bad_reg;
            s4_total_reg <= total_next;
        end
    end

    // stage 5: status
    always_comb
    begin
        if (s4_bad_reg)
        begin
            status_next = ST_BAD_DATE;
        end
        else if (s4_total_reg[TOTAL_W-1] || (s4_total_reg >= TOTAL_W'(DAYS_TOTAL)))
        begin
            status_next = ST_RANGE;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_status_reg <= status_next;
            s5_t_reg      <= s4_total_reg[DCNT_W-1:0];
        end
    end

    // stage 6: year estimate and octal digit sum for mod 7
    assign est_prod = s5_t_reg * RECIP_YEAR;
    assign ry0_next = est_prod[RECIP_YEAR_SH +: YEAR_W] + YEAR_W'(FIRST_YEAR);

    always_comb
    begin
        dsum_next = DSUM_W'(s5_t_reg[DCNT_W-1]);
        for (int i = 0; i < DCNT_W / 3; i++)
        begin
            dsum_next = dsum_next + DSUM_W'(s5_t_reg[3*i +: 3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_status_reg <= s5_status_reg;
            s6_t_reg      <= s5_t_reg;
            s6_ry0_reg    <= ry0_next;
            s6_dsum_reg   <= dsum_next;
        end
    end

    // days to the start of the estimated year, ready at stage 8
    gdo_year_days u_inv_year (
        .clk  (clk),
        .en   (en),
        .year (s6_ry0_reg),
        .days (inv_days),
        .leap (inv_leap)
    );

    // stage 7: fold digit sum into the count mod 7
    assign fold    = 4'(s6_dsum_reg[5:3]) + 4'(s6_dsum_reg[2:0]);
    assign m7_next = (fold >= 4'd7) ? WDAY_W'(fold - 4'd7) : WDAY_W'(fold);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_status_reg <= s6_status_reg;
            s7_t_reg      <= s6_t_reg;
            s7_ry0_reg    <= s6_ry0_reg;
            s7_m7_reg     <= m7_next;
        end
    end

    // stage 8: weekday, day zero is a wednesday
    assign wday_next = (s7_m7_reg <= 3'd4) ? s7_m7_reg + 3'd3 : s7_m7_reg - 3'd4;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_status_reg <= s7_status_reg;
            s8_t_reg      <= s7_t_reg;
            s8_ry0_reg    <= s7_ry0_reg;
            s8_wday_reg   <= wday_next;
        end
    end

    // stage 9: distance from the estimated year start
    assign diff_next = {1'b0, s8_t_reg} - {1'b0, inv_days};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_status_reg <= s8_status_reg;
            s9_t_reg      <= s8_t_reg;
            s9_ry0_reg    <= s8_ry0_reg;
            s9_wday_reg   <= s8_wday_reg;
            s9_diff_reg   <= diff_next;
            s9_leap_reg   <= inv_leap;
        end
    end

    // stage 10: correct the estimate by one year either way
    assign len_cur = 10'd365 + 10'(s9_leap_reg.cur);

    always_comb
    begin
        if (s9_diff_reg[DIFF_W-1])
        begin
            ry_next   = s9_ry0_reg - 14'd1;
            rest_next = s9_diff_reg[DOY_W-1:0] + 9'd365 + DOY_W'(s9_leap_reg.prev);
            lp_next   = s9_leap_reg.prev;
        end
        else if (s9_diff_reg >= DIFF_W'(len_cur))
        begin
            ry_next   = s9_ry0_reg + 14'd1;
            rest_next = s9_diff_reg[DOY_W-1:0] - len_cur[DOY_W-1:0];
            lp_next   = s9_leap_reg.next;
        end
        else
        begin
            ry_next   = s9_ry0_reg;
            rest_next = s9_diff_reg[DOY_W-1:0];
            lp_next   = s9_leap_reg.cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_status_reg <= s9_status_reg;
            s10_t_reg      <= s9_t_reg;
            s10_ry_reg     <= ry_next;
            s10_wday_reg   <= s9_wday_reg;
            s10_rest_reg   <= rest_next;
            s10_leap_reg   <= lp_next;
        end
    end

    // stage 11: month and day of month
    gdo_month_split u_split (
        .clk   (clk),
        .en    (en),
        .rest  (s10_rest_reg),
        .leap  (s10_leap_reg),
        .month (split_month),
        .day   (split_day)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_status_reg <= s10_status_reg;
            s11_t_reg      <= s10_t_reg;
            s11_ry_reg     <= s10_ry_reg;
            s11_wday_reg   <= s10_wday_reg;
        end
    end

    // stage 12: output register, result fields cleared on any error
    assign ok = (s11_status_reg == ST_OK);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= s11_status_reg;
            day_reg    <= ok ? split_day    : '0;
            month_reg  <= ok ? split_month  : '0;
            year_reg   <= ok ? s11_ry_reg   : '0;
            wday_reg   <= ok ? s11_wday_reg : '0;
            count_reg  <= ok ? s11_t_reg    : '0;
        end
    end

    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign status    = status_reg;
    assign day_out   = day_reg;
    assign month_out = month_reg;
    assign year_out  = year_reg;
    assign weekday   = wday_reg;
    assign day_count = count_reg;

endmodule

// ===== rtl/gdo_year_days.sv =====
// two-stage unit: days from the first year to 1 January of a year, plus leap flags
module gdo_year_days
    import gdo_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [YEAR_W-1:0] year,
    output logic [DCNT_W-1:0] days,
    output leap_t             leap
);

    logic [YEAR_W-1:0]       prior;
    logic [YEAR_W-1:0]       span;
    logic [DCNT_W:0]         base_full;
    logic [QUART_W-1:0]      quart_next;
    logic [2*QUART_W-1:0]    prod_next;

    logic [QUART_W-1:0]      quart_reg;
    logic [2*QUART_W-1:0]    prod_reg;
    logic [DCNT_W-1:0]       base_reg;
    logic [1:0]              plow_reg;

    logic [CENT_W-1:0]       cent;
    logic [CENT_W+4:0]       cent25;
    logic [4:0]              rem25;
    logic [DCNT_W-1:0]       leaps_rel;
    logic [DCNT_W-1:0]       days_next;
    leap_t                   leap_next;

    logic [DCNT_W-1:0]       days_reg;
    leap_t                   leap_reg;

    // stage one: quarter of (year-1), its reciprocal product and 365 days per year
    assign prior      = year - 14'd1;
    assign span       = year - YEAR_W'(FIRST_YEAR);
    assign quart_next = prior[YEAR_W-1:2];
    assign prod_next  = quart_next * RECIP_25;
    assign base_full  = span * 9'd365;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quart_reg <= quart_next;
            prod_reg  <= prod_next;
            base_reg  <= base_full[DCNT_W-1:0];
            plow_reg  <= prior[1:0];
        end
    end

    // stage two: centuries, leap count and leap flags around the year
    assign cent      = prod_reg[RECIP_25_SH +: CENT_W];
    assign cent25    = 13'({cent, 4'b0000}) + 13'({cent, 3'b000}) + 13'(cent);
    assign rem25     = quart_reg[4:0] - cent25[4:0];
    assign leaps_rel = DCNT_W'(quart_reg) - DCNT_W'(cent) + DCNT_W'(cent[CENT_W-1:2])
                     - DCNT_W'(LEAPS_FIRST);
    assign days_next = base_reg + leaps_rel;

    always_comb
    begin
        leap_next.prev = (plow_reg == 2'd0) && ((rem25 != 5'd0) || (cent[1:0] == 2'd0));
        leap_next.cur  = (plow_reg == 2'd3) && ((rem25 != 5'd24) || (cent[1:0] == 2'd3));
        leap_next.next = (plow_reg == 2'd2) && ((rem25 != 5'd24) || (cent[1:0] == 2'd3));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            days_reg <= days_next;
            leap_reg <= leap_next;
        end
    end

    assign days = days_reg;
    assign leap = leap_reg;

endmodule

// ===== rtl/gdo_month_split.sv =====
// splits a day of the year into month and day of month, one register stage
module gdo_month_split
    import gdo_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [DOY_W-1:0]   rest,
    input  logic               leap,
    output logic [MONTH_W-1:0] month,
    output logic [DAY_W-1:0]   day
);

    logic [MONTH_W-1:0] month_next;
    logic [DOY_W-1:0]   start_next;
    logic [MONTH_W-1:0] month_reg;
    logic [DOY_W-1:0]   start_reg;
    logic [DOY_W-1:0]   rest_reg;
    logic [DOY_W-1:0]   day_full;

    // last month whose first day is not past the day of the year
    always_comb
    begin : month_pick
        logic [DOY_W-1:0] st;
        month_next = 4'd1;
        start_next = '0;
        for (int k = 2; k <= 12; k++)
        begin
            st = month_start(MONTH_W'(k), leap);
            if (rest >= st)
            begin
                month_next = MONTH_W'(k);
                start_next = st;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            month_reg <= month_next;
            start_reg <= start_next;
            rest_reg  <= rest;
        end
    end

    // day of month from the month's first day
    assign day_full = rest_reg - start_reg + 9'd1;
    assign month    = month_reg;
    assign day      = day_full[DAY_W-1:0];

endmodule

// ===== rtl/gdo_port_checker.sv =====
// port-level checker for the date offset block and its bind
`include "gregorian_date_offset_assert.svh"

module gdo_port_checker
    import gdo_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [STATUS_W-1:0]     status,
    input logic [DAY_W-1:0]        day_out,
    input logic [MONTH_W-1:0]      month_out,
    input logic [YEAR_W-1:0]       year_out,
    input logic [WDAY_W-1:0]       weekday,
    input logic [DCNT_W-1:0]       day_count
);

    logic [STATUS_W+DAY_W+MONTH_W+YEAR_W+WDAY_W+DCNT_W-1:0] out_word;
    logic out_err;
    logic out_good;
    logic fields_zero;
    logic fields_sane;

    // whole result payload and its classes
    assign out_word = {status, day_out, month_out, year_out, weekday, day_count};
    assign out_err  = out_valid && ((status == ST_BAD_DATE) || (status == ST_RANGE));
    assign out_good = out_valid && (status == ST_OK);

    // no date fields on an error result
    assign fields_zero = (day_out == 5'd0) && (month_out == 4'd0) && (year_out == 14'd0)
                      && (weekday == 3'd0) && (day_count == 22'd0);

    // date fields within calendar limits
    assign fields_sane = (month_out != 4'd0) && (month_out <= 4'd12) && (day_out != 5'd0)
                      && (weekday != 3'd0) && (year_out >= YEAR_W'(FIRST_YEAR))
                      && (year_out <= YEAR_W'(LAST_YEAR));

    // input side is held back only by a waiting result
    `GDO_CHECK(a_stall_cause, in_stall, out_valid && out_stall)

    // a stalled result keeps its payload
    `GDO_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    // error transactions carry no date
    `GDO_CHECK(a_err_clear, out_err, fields_zero)

    // good transactions carry a date in range
    `GDO_CHECK(a_ok_fields, out_good, fields_sane)

endmodule

bind gregorian_date_offset gdo_port_checker u_port_checker (.*);

// ===== verif/gregorian_date_offset_test.sv =====
// self-checking testbench for the gregorian date offset block
module gregorian_date_offset_test
    import gdo_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1950;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 16;

    // expected fields of one result transaction
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [WDAY_W-1:0]   wday;
        logic [DCNT_W-1:0]   count;
    } shifted_date_t;

    // calendar arithmetic and the queue of shifted dates still owed by the block
    class date_scoreboard;
        shifted_date_t awaited[$];
        int unsigned   mismatches;

        function bit leap_year(longint y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        function longint month_days(longint m, longint y);
            case (m)
                2:           return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        // leap years from year 1 up to but not including y
        function longint leaps_up_to(longint y);
            return (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
        endfunction

        // days from the epoch to 1 january of year y
        function longint year_start(longint y);
            return 365 * (y - FIRST_YEAR) + leaps_up_to(y) - leaps_up_to(FIRST_YEAR);
        endfunction

        // days from the epoch to a valid date
        function longint day_number(longint d, longint m, longint y);
            longint s;
            s = year_start(y);
            for (longint i = 1; i < m; i++)
                s += month_days(i, y);
            return s + d - 1;
        endfunction

        function shifted_date_t shift_date(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                           logic [YEAR_W-1:0] y, logic signed [OFF_W-1:0] off);
            shifted_date_t r;
            longint        t;
            longint        ry;
            longint        rm;
            longint        rest;
            r = '{default: '0};
            // starting date check
            if (y < FIRST_YEAR || y > LAST_YEAR || m < 1 || m > 12 || d < 1
                || d > month_days(m, y))
            begin
                r.status = ST_BAD_DATE;
                return r;
            end
            t = day_number(d, m, y) + longint'(off);
            if (t < 0 || t >= year_start(LAST_YEAR + 1))
            begin
                r.status = ST_RANGE;
                return r;
            end
            // year from an estimate, then corrected
            ry = FIRST_YEAR + (t * 400) / 146097;
            if (ry > LAST_YEAR)
                ry = LAST_YEAR;
            while (ry > FIRST_YEAR && year_start(ry) > t)
                ry--;
            while (ry < LAST_YEAR && year_start(ry + 1) <= t)
                ry++;
            // month and day within that year
            rest = t - year_start(ry);
            rm = 1;
            while (rm < 12 && rest >= month_days(rm, ry))
            begin
                rest -= month_days(rm, ry);
                rm++;
            end
            r.status = ST_OK;
            r.day    = rest + 1;
            r.month  = rm;
            r.year   = ry;
            r.wday   = (2 + t % 7) % 7 + 1;
            r.count  = t;
            return r;
        endfunction

        function void note_input(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                 logic [YEAR_W-1:0] y, logic signed [OFF_W-1:0] off);
            awaited.push_back(shift_date(d, m, y, off));
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(shifted_date_t got);
            shifted_date_t want;
            if (awaited.size() == 0)
            begin
                $error("result transaction with none pending, status %0d", got.status);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            field_check("status", want.status, got.status);
            field_check("day_out", want.day, got.day);
            field_check("month_out", want.month, got.month);
            field_check("year_out", want.year, got.year);
            field_check("weekday", want.wday, got.wday);
            field_check("day_count", want.count, got.count);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [DAY_W-1:0]        day_in = '0;
    logic [MONTH_W-1:0]      month_in = '0;
    logic [YEAR_W-1:0]       year_in = '0;
    logic signed [OFF_W-1:0] day_offset = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [DAY_W-1:0]        day_out;
    logic [MONTH_W-1:0]      month_out;
    logic [YEAR_W-1:0]       year_out;
    logic [WDAY_W-1:0]       weekday;
    logic [DCNT_W-1:0]       day_count;

    int                      idle_pct = 0;
    int                      stall_pct = 0;
    int unsigned             quiet_cycles = 0;
    date_scoreboard          sb = new();

    gregorian_date_offset u_dut (.*);

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(day_in, month_in, year_in, day_offset);
            if (out_valid && !out_stall)
                sb.check_result('{status, day_out, month_out, year_out, weekday, day_count});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                quiet_cycles++;
        end
    end

    // one input transaction, after a random sender gap
    task automatic send_item(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                             input logic [YEAR_W-1:0] y, input logic signed [OFF_W-1:0] off);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        day_in     <= d;
        month_in   <= m;
        year_in    <= y;
        day_offset <= off;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // mostly valid dates with offsets aimed inside the range, plus noise and bad dates
    task automatic send_random();
        int                      kind;
        int                      pick;
        longint                  span;
        longint                  start;
        longint                  r;
        logic [DAY_W-1:0]        d;
        logic [MONTH_W-1:0]      m;
        logic [YEAR_W-1:0]       y;
        logic signed [OFF_W-1:0] off;
        kind = $urandom_range(99);
        span = sb.year_start(LAST_YEAR + 1);
        if (kind < 12)
        begin
            d   = $urandom;
            m   = $urandom;
            y   = $urandom;
            off = $urandom;
        end
        else
        begin
            pick = $urandom_range(9);
            if (pick < 2)
            begin
                case ($urandom_range(6))
                    0:       y = FIRST_YEAR;
                    1:       y = 1900;
                    2:       y = 2000;
                    3:       y = 2100;
                    4:       y = 2400;
                    5:       y = LAST_YEAR - 3;
                    default: y = LAST_YEAR;
                endcase
            end
            else
                y = $urandom_range(LAST_YEAR, FIRST_YEAR);
            m = (pick == 2 || pick == 3) ? 2 : $urandom_range(12, 1);
            d = $urandom_range(sb.month_days(m, y), 1);
            start = sb.day_number(d, m, y);
            r = $urandom_range(2);
            case ($urandom_range(9))
                0, 1:    off = int'($urandom_range(800)) - 400;
                2, 3:    off = int'($urandom_range(80000)) - 40000;
                4, 5, 6: off = longint'($urandom_range(span - 1)) - start;
                7:       off = $urandom;
                // results on and just past both ends of the calendar
                default:
                begin
                    case ($urandom_range(3))
                        0:       off = -1 - r - start;
                        1:       off = r - start;
                        2:       off = span - 1 - r - start;
                        default: off = span + r - start;
                    endcase
                end
            endcase
            // a broken starting date
            if (kind < 22)
            begin
                case ($urandom_range(3))
                    0:       d = (sb.month_days(m, y) == 31) ? 0 : sb.month_days(m, y) + 1;
                    1:       d = 0;
                    2:       m = $urandom_range(1) ? 0 : $urandom_range(15, 13);
                    default: y = $urandom_range(1) ? FIRST_YEAR - 1 - $urandom_range(100)
                                                   : LAST_YEAR + 1 + $urandom_range(100);
                endcase
            end
        end
        send_item(d, m, y, off);
    endtask

    // stimulus and end of run
    initial
    begin
        longint span;
        span = sb.year_start(LAST_YEAR + 1);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // calendar ends, zero offset and offset extremes
        send_item(1, 1, FIRST_YEAR, 0);
        send_item(31, 12, LAST_YEAR, 0);
        send_item(1, 1, FIRST_YEAR, -1);
        send_item(31, 12, LAST_YEAR, 1);
        send_item(1, 1, FIRST_YEAR, span - 1);
        send_item(31, 12, LAST_YEAR, 1 - span);
        send_item(1, 1, FIRST_YEAR, 23'sh3FFFFF);
        send_item(31, 12, LAST_YEAR, 23'sh400000);
        send_item(15, 6, 5000, 23'sh3FFFFF);
        // leap day rules
        send_item(29, 2, 2000, 0);
        send_item(29, 2, 1900, 0);
        send_item(29, 2, 2024, 365);
        send_item(29, 2, 2023, 0);
        send_item(30, 2, 2000, 0);
        send_item(28, 2, 1900, 1);
        // day past month end and field extremes
        send_item(31, 4, 2001, 0);
        send_item(31, 1, 2001, 30);
        send_item(0, 5, 2001, 0);
        send_item(10, 0, 2001, 0);
        send_item(10, 13, 2001, 0);
        send_item(10, 15, 2001, 0);
        send_item(10, 5, FIRST_YEAR - 1, 0);
        send_item(10, 5, LAST_YEAR + 1, 0);
        send_item(10, 5, 14'h3FFF, 0);

        // random transactions over the idle and stall phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 83; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 6;  stall_pct = 6;  end
            endcase
            repeat (RANDOM_ITEMS / 4)
                send_random();
        end

        // drain
        in_valid <= 1'b0;
        stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
